FILE: rtl/rgbc_pkg.sv
`default_nettype none
package rgbc_pkg;
	localparam int CountW = 16;
	localparam int PctW = 7;
	localparam int HueW = 9;
	localparam int QuoW = 7;
	localparam int ScaledW = CountW + PctW;
	localparam int HueNumW = 13;
	localparam int SatNumW = 14;
	localparam int SatDenW = 8;

	localparam logic [PctW-1:0] PctFull = 7'd100;
	localparam logic [PctW-1:0] PctHalf = 7'd50;
	localparam logic [SatDenW-1:0] SumFull = 8'd200;
	localparam logic [5:0] HueStep = 6'd60;

	// sector holding the maximum channel
	localparam logic [1:0] SecRedUp = 2'd0;
	localparam logic [1:0] SecRedDn = 2'd1;
	localparam logic [1:0] SecGreen = 2'd2;
	localparam logic [1:0] SecBlue = 2'd3;

	typedef struct packed {
		logic [1:0] sector;
		logic neg;
		logic grey;
		logic inv;
	} hue_side_t;
endpackage
`default_nettype wire

FILE: rtl/rgbc_div.sv
`default_nettype none
module rgbc_div #(
	parameter int NW = 23,
	parameter int DW = 16,
	parameter int QW = 7,
	parameter int SW = 1
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic in_valid,
	input wire logic [NW-1:0] num,
	input wire logic [DW-1:0] den,
	input wire logic [SW-1:0] side,
	output logic out_valid,
	output logic [QW-1:0] quo,
	output logic [SW-1:0] side_out
);
	// restoring division, one quotient bit per stage; needs num < den * 2**QW
	localparam int CW = (NW > DW + QW) ? NW : DW + QW;

	logic [CW-1:0] rem_s [1:QW];
	logic [QW-1:0] quo_s [1:QW];
	logic [DW-1:0] den_s [1:QW];
	logic [SW-1:0] side_s [1:QW];
	logic [QW:1] valid_s;

	for (genvar i = 0; i < QW; i++) begin : g_stage
		logic [CW-1:0] rem_in;
		logic [QW-1:0] quo_in;
		logic [DW-1:0] den_in;
		logic [SW-1:0] side_in;
		logic v_in;
		logic [CW-1:0] dsh;
		logic ge;

		if (i == 0) begin : g_first
			assign rem_in = CW'(num);
			assign quo_in = '0;
			assign den_in = den;
			assign side_in = side;
			assign v_in = in_valid;
		end else begin : g_next
			assign rem_in = rem_s[i];
			assign quo_in = quo_s[i];
			assign den_in = den_s[i];
			assign side_in = side_s[i];
			assign v_in = valid_s[i];
		end

		assign dsh = CW'(den_in) << (QW - 1 - i);
		assign ge = rem_in >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i+1] <= 1'b0;
			end else if (en) begin
				valid_s[i+1] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? rem_in - dsh : rem_in;
				quo_s[i+1] <= ge ? quo_in | (QW'(1) << (QW - 1 - i)) : quo_in;
				den_s[i+1] <= den_in;
				side_s[i+1] <= side_in;
			end
		end
	end

	assign out_valid = valid_s[QW];
	assign quo = quo_s[QW];
	assign side_out = side_s[QW];
endmodule
`default_nettype wire

FILE: rtl/rgbc_to_hsl_integer.sv
`default_nettype none
// Channel  Dir  Bits  Contents (lowest bit first)
// s_axis   in   64    red_count, green_count, blue_count, clear_count
// m_axis   out  24    hue_deg, saturation_pct, lightness_pct, result_valid
//
// The pipeline is: one input register, seven stages of the channel
// scaling divider (one quotient bit per stage), clamp, max/min, operand
// forming, seven stages of the hue and saturation dividers, output register.
// One sample is taken every cycle unless stalled. The whole pipeline advances
// together while the output register is empty or its transfer completes; a
// stall freezes it. Reset clears only the valid bits.
module rgbc_to_hsl_integer (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [63:0] s_tdata, // red_count, green_count, blue_count, clear_count
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [23:0] m_tdata // hue_deg, saturation_pct, lightness_pct, result_valid
);
	import rgbc_pkg::*;

	logic en;
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	// stage 1: register the counts
	logic v_s1;
	logic [CountW-1:0] cnt_s1 [0:2];
	logic [CountW-1:0] clr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cnt_s1[0] <= s_tdata[15:0];
			cnt_s1[1] <= s_tdata[31:16];
			cnt_s1[2] <= s_tdata[47:32];
			clr_s1 <= s_tdata[63:48];
		end
	end

	// scale each channel: count * 100 / clear; flag quotients past the divider range
	logic [ScaledW-1:0] num_c [0:2];
	logic [2:0] big_c;
	logic inv_c;
	assign inv_c = clr_s1 == '0;
	for (genvar c = 0; c < 3; c++) begin : g_scale
		assign num_c[c] = ScaledW'(cnt_s1[c]) * ScaledW'(PctFull);
		assign big_c[c] = num_c[c][ScaledW-1:QuoW] >= clr_s1;
	end

	logic [2:0] dv;
	logic [QuoW-1:0] dq [0:2];
	logic [3:0] dside [0:2];
	for (genvar c = 0; c < 3; c++) begin : g_div
		rgbc_div #(.NW(ScaledW), .DW(CountW), .QW(QuoW), .SW(4)) u_div (
			.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s1),
			.num(num_c[c]), .den(clr_s1), .side({inv_c, big_c}),
			.out_valid(dv[c]), .quo(dq[c]), .side_out(dside[c])
		);
	end

	// clamp stage: saturate at 100
	logic v_s2, inv_s2;
	logic [PctW-1:0] pct_s2 [0:2];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= &dv;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			inv_s2 <= dside[0][3];
			for (int c = 0; c < 3; c++) begin
				pct_s2[c] <= (dside[0][c] || dq[c] > PctFull) ? PctFull : dq[c];
			end
		end
	end

	// max / min stage; ties go red, then green, then blue
	logic [PctW-1:0] r2, g2, b2, mx_c, mn_c;
	logic [1:0] sec_c;
	assign r2 = pct_s2[0];
	assign g2 = pct_s2[1];
	assign b2 = pct_s2[2];
	always_comb begin
		mx_c = r2;
		if (g2 > mx_c) mx_c = g2;
		if (b2 > mx_c) mx_c = b2;
		mn_c = r2;
		if (g2 < mn_c) mn_c = g2;
		if (b2 < mn_c) mn_c = b2;
		if (mx_c == r2) sec_c = (g2 >= b2) ? SecRedUp : SecRedDn;
		else if (mx_c == g2) sec_c = SecGreen;
		else sec_c = SecBlue;
	end

	logic v_s3, inv_s3;
	logic [1:0] sec_s3;
	logic [PctW-1:0] dif_s3, r_s3, g_s3, b_s3;
	logic [SatDenW-1:0] sum_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			inv_s3 <= inv_s2;
			sec_s3 <= sec_c;
			dif_s3 <= mx_c - mn_c;
			sum_s3 <= SatDenW'(mx_c) + SatDenW'(mn_c);
			r_s3 <= r2;
			g_s3 <= g2;
			b_s3 <= b2;
		end
	end

	// operand stage: hue and saturation numerators and denominators
	logic [PctW-1:0] ha, hb, hdiff, lig_c;
	logic hneg;
	always_comb begin
		case (sec_s3)
			SecRedUp, SecRedDn: begin
				ha = g_s3;
				hb = b_s3;
			end
			SecGreen: begin
				ha = b_s3;
				hb = r_s3;
			end
			default: begin
				ha = r_s3;
				hb = g_s3;
			end
		endcase
		hneg = ha < hb;
		hdiff = hneg ? hb - ha : ha - hb;
	end
	assign lig_c = sum_s3[SatDenW-1:1];

	logic v_s4;
	logic [HueNumW-1:0] hnum_s4;
	logic [PctW-1:0] hden_s4, lig_s4;
	logic [SatNumW-1:0] snum_s4;
	logic [SatDenW-1:0] sden_s4;
	hue_side_t hside_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			hnum_s4 <= HueNumW'(hdiff) * HueNumW'(HueStep);
			hden_s4 <= dif_s3;
			snum_s4 <= SatNumW'(dif_s3) * SatNumW'(PctFull);
			sden_s4 <= (lig_c <= PctHalf) ? sum_s3 : SumFull - sum_s3;
			lig_s4 <= lig_c;
			hside_s4 <= '{sector: sec_s3, neg: hneg, grey: dif_s3 == '0, inv: inv_s3};
		end
	end

	logic hv, sv;
	logic [QuoW-1:0] hq, sq;
	hue_side_t hside_o;
	logic [PctW-1:0] lig_o;

	rgbc_div #(.NW(HueNumW), .DW(PctW), .QW(QuoW), .SW($bits(hue_side_t))) u_hue_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s4),
		.num(hnum_s4), .den(hden_s4), .side(hside_s4),
		.out_valid(hv), .quo(hq), .side_out(hside_o)
	);

	rgbc_div #(.NW(SatNumW), .DW(SatDenW), .QW(QuoW), .SW(PctW)) u_sat_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s4),
		.num(snum_s4), .den(sden_s4), .side(lig_s4),
		.out_valid(sv), .quo(sq), .side_out(lig_o)
	);

	// output stage: add or subtract the hue term from the sector base
	logic [HueW-1:0] base_c, hue_c;
	always_comb begin
		case (hside_o.sector)
			SecRedUp: base_c = 9'd0;
			SecRedDn: base_c = 9'd360;
			SecGreen: base_c = 9'd120;
			default: base_c = 9'd240;
		endcase
		hue_c = hside_o.neg ? base_c - HueW'(hq) : base_c + HueW'(hq);
	end

	logic [HueW-1:0] hue_q;
	logic [PctW-1:0] sat_q, lig_q;
	logic ok_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= hv & sv;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			// drop everything to zero for an empty clear count; grey zeroes hue and saturation
			hue_q <= (hside_o.inv || hside_o.grey) ? '0 : hue_c;
			sat_q <= (hside_o.inv || hside_o.grey) ? '0 : sq;
			lig_q <= hside_o.inv ? '0 : lig_o;
			ok_q <= !hside_o.inv;
		end
	end

	assign m_tdata = {ok_q, lig_q, sat_q, hue_q};
endmodule
`default_nettype wire

FILE: sim/rgbc_to_hsl_integer_tb.sv
`timescale 1ns / 100ps
module rgbc_to_hsl_integer_tb;
	import rgbc_pkg::*;

	typedef struct packed {
		logic [CountW-1:0] clear_count;
		logic [CountW-1:0] blue_count;
		logic [CountW-1:0] green_count;
		logic [CountW-1:0] red_count;
	} sample_t;

	typedef struct packed {
		logic result_valid;
		logic [PctW-1:0] lightness_pct;
		logic [PctW-1:0] saturation_pct;
		logic [HueW-1:0] hue_deg;
	} hsl_t;

	localparam int Latency = 19;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [63:0] s_tdata; // red_count, green_count, blue_count, clear_count
	logic m_tvalid;
	logic m_tready;
	logic [23:0] m_tdata; // hue_deg, saturation_pct, lightness_pct, result_valid

	hsl_t expected_hsl[$];
	int n_errors;
	int n_results;
	int n_samples;
	bit hold_off;     // long receiver stall in progress
	int hold_cycles;

	rgbc_to_hsl_integer dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("timeout: %0d results still outstanding", expected_hsl.size());
		$display("CHECKS FAILED");
		$finish;
	end

	// Scale a count to percent of clear, truncate and clamp at full scale.
	function automatic int unsigned pct_of_clear(int unsigned cnt, int unsigned clr);
		int unsigned q;
		q = (cnt * 100) / clr;
		return (q > 100) ? 100 : q;
	endfunction

	// Predict the HSL result of one sample.
	function automatic hsl_t predict_hsl(sample_t smp);
		hsl_t res;
		int unsigned r, g, b, mx, mn, dif, sum, lgt;
		int hue, sat;
		res = '0;
		if (smp.clear_count == 0)
			return res;
		r = pct_of_clear(smp.red_count, smp.clear_count);
		g = pct_of_clear(smp.green_count, smp.clear_count);
		b = pct_of_clear(smp.blue_count, smp.clear_count);
		mx = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		mn = r;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		dif = mx - mn;
		sum = mx + mn;
		lgt = sum / 2;
		hue = 0;
		sat = 0;
		if (dif != 0) begin
			// signed terms truncate toward zero
			if (mx == r) begin
				if (g >= b) hue = (60 * (int'(g) - int'(b))) / int'(dif);
				else hue = 360 - (60 * (int'(b) - int'(g))) / int'(dif);
			end else if (mx == g) begin
				hue = 120 + (60 * (int'(b) - int'(r))) / int'(dif);
			end else begin
				hue = 240 + (60 * (int'(r) - int'(g))) / int'(dif);
			end
			if (lgt <= 50) sat = (dif * 100) / sum;
			else sat = (dif * 100) / (200 - sum);
		end
		res.hue_deg = hue[HueW-1:0];
		res.saturation_pct = sat[PctW-1:0];
		res.lightness_pct = lgt[PctW-1:0];
		res.result_valid = 1'b1;
		return res;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch at result %0d: %s got %0d expected %0d",
			n_results, what, got, want);
		n_errors++;
	endtask

	// Receiver: random ready, long hold-off on request.
	initial begin
		int wait_n;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				m_tready <= 1'b0;
				repeat (hold_cycles) @(negedge clk);
				hold_off = 1'b0;
			end
			wait_n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : 0;
			if (wait_n > 0) begin
				m_tready <= 1'b0;
				repeat (wait_n - 1) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Checker: compare each transfer with the oldest prediction.
	initial begin
		hsl_t got, want;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				got = m_tdata;
				if (expected_hsl.size() == 0) begin
					report_mismatch("unexpected result", int'(m_tdata), 0);
				end else begin
					want = expected_hsl.pop_front();
					if (got.hue_deg !== want.hue_deg)
						report_mismatch("hue_deg", got.hue_deg, want.hue_deg);
					if (got.saturation_pct !== want.saturation_pct)
						report_mismatch("saturation_pct", got.saturation_pct,
							want.saturation_pct);
					if (got.lightness_pct !== want.lightness_pct)
						report_mismatch("lightness_pct", got.lightness_pct,
							want.lightness_pct);
					if (got.result_valid !== want.result_valid)
						report_mismatch("result_valid", got.result_valid,
							want.result_valid);
				end
				n_results++;
			end
		end
	end

	// Offer one sample after a random gap and hold it until the transfer.
	task automatic send_sample(sample_t smp, bit no_gap = 0);
		int gap;
		gap = no_gap ? 0 : (($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : 0);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= smp;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_hsl.push_back(predict_hsl(smp));
		n_samples++;
		@(negedge clk);
		// keep tvalid high; the next call or the caller lowers it
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_hsl.size() != 0) @(negedge clk);
	endtask

	function automatic sample_t make_sample(int r, int g, int b, int c);
		sample_t smp;
		smp.red_count = CountW'(r);
		smp.green_count = CountW'(g);
		smp.blue_count = CountW'(b);
		smp.clear_count = CountW'(c);
		return smp;
	endfunction

	// Field extremes, grey, zero clear, clamping, every sector and ties.
	task automatic test_directed();
		send_sample(make_sample(0, 0, 0, 0));
		send_sample(make_sample(65535, 65535, 65535, 0));
		send_sample(make_sample(0, 0, 0, 65535));
		send_sample(make_sample(65535, 65535, 65535, 65535));
		send_sample(make_sample(65535, 0, 0, 1));        // clamp red
		send_sample(make_sample(65535, 65535, 65535, 1)); // grey at full
		send_sample(make_sample(50, 50, 50, 100));       // grey mid
		send_sample(make_sample(100, 30, 10, 100));      // red max, green up
		send_sample(make_sample(100, 10, 30, 100));      // red max, green below blue
		send_sample(make_sample(100, 0, 1, 100));        // hue wraps to 360
		send_sample(make_sample(20, 90, 40, 100));       // green max
		send_sample(make_sample(60, 90, 10, 100));       // green max, blue below red
		send_sample(make_sample(30, 10, 80, 100));       // blue max
		send_sample(make_sample(10, 30, 80, 100));       // blue max, red below green
		send_sample(make_sample(80, 80, 10, 100));       // red/green tie
		send_sample(make_sample(10, 80, 80, 100));       // green/blue tie
		send_sample(make_sample(80, 10, 80, 100));       // red/blue tie
		send_sample(make_sample(100, 99, 0, 100));       // lightness exactly 50
		send_sample(make_sample(1, 0, 0, 100));          // tiny saturation sum
		send_sample(make_sample(100, 100, 99, 100));     // near-white
		send_sample(make_sample(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
		send_sample(make_sample(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));
		drain_results();
	endtask

	function automatic sample_t random_sample();
		sample_t smp;
		int unsigned clr;
		case ($urandom_range(0, 9))
			0: smp = {$urandom, $urandom};                       // full noise
			1: smp = make_sample($urandom_range(0, 65535), $urandom_range(0, 65535),
				$urandom_range(0, 65535), 0);
			2: begin                                             // small clear
				clr = $urandom_range(1, 255);
				smp = make_sample($urandom_range(0, 300), $urandom_range(0, 300),
					$urandom_range(0, 300), clr);
			end
			default: begin                                       // colours under clear
				clr = $urandom_range(1, 65535);
				smp = make_sample($urandom_range(0, clr), $urandom_range(0, clr),
					$urandom_range(0, clr), clr);
			end
		endcase
		return smp;
	endfunction

	task automatic test_random(int count);
		repeat (count) send_sample(random_sample());
		drain_results();
	endtask

	// Back-to-back offers against a long stall: the pipeline fills and stalls.
	task automatic test_backpressure();
		hold_cycles = 60;
		hold_off = 1'b1;
		repeat (80) send_sample(random_sample(), 1);
		drain_results();
		// sender pauses until all results are back, then resumes
		repeat (20) send_sample(random_sample());
		drain_results();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		hold_off = 1'b0;
		hold_cycles = 0;
		n_errors = 0;
		n_results = 0;
		n_samples = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_backpressure();
		test_random(1250);

		repeat (Latency + 5) @(negedge clk);
		$display("covered %0d samples and %0d results: extremes, zero clear, grey,",
			n_samples, n_results);
		$display("clamping, all hue sectors and ties, long output stall, random gaps");
		if (n_errors == 0 && expected_hsl.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule

FILE: files.f
rtl/rgbc_pkg.sv
rtl/rgbc_div.sv
rtl/rgbc_to_hsl_integer.sv
sim/rgbc_to_hsl_integer_tb.sv
